@@ src/bfis_pkg.sv @@
package bfis_pkg;

  // Default sizes of the program store and the tape.
  localparam int unsigned DEF_PROGRAM_BYTES = 512;
  localparam int unsigned DEF_TAPE_CELLS    = 300;

  // Width of the program length register.
  localparam int unsigned LEN_W = 10;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Status codes reported with every result.
  localparam logic [2:0] ST_RUNNING    = 3'd0;
  localparam logic [2:0] ST_FINISHED   = 3'd1;
  localparam logic [2:0] ST_BOUNDS     = 3'd2;
  localparam logic [2:0] ST_UNMATCHED  = 3'd3;
  localparam logic [2:0] ST_NEED_INPUT = 3'd4;

  // The eight command characters.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_WIPE,
    S_DONE
  } state_e;

  // One input item.
  typedef struct packed {
    logic [1:0] operation;
    logic [8:0] program_address;
    logic [7:0] program_byte;
    logic       input_present;
    logic [7:0] input_byte;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [2:0] status;
    logic       output_valid;
    logic [7:0] output_byte;
  } out_t;

endpackage

@@ src/bfis_tape.sv @@
module bfis_tape #(
  parameter int unsigned TAPE_CELLS = 300
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  output logic                          busy_o,
  input  logic                          rd_en_i,
  input  logic [$clog2(TAPE_CELLS)-1:0] rd_addr_i,
  output logic [7:0]                    rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(TAPE_CELLS)-1:0] wr_addr_i,
  input  logic [7:0]                    wr_data_i
);

  localparam int unsigned TW = $clog2(TAPE_CELLS);

  logic [7:0]    mem [TAPE_CELLS];
  logic [7:0]    rd_data_q;
  logic          busy_q, busy_d;
  logic [TW-1:0] clr_q, clr_d;

  // Sweep control: one cell is zeroed per cycle, after reset and on request.
  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (clear_i) begin
      busy_d = 1'b1;
      clr_d  = '0;
    end else if (busy_q) begin
      if (clr_q == TW'(TAPE_CELLS - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  // Single write port shared by the sweep and the controller, registered read.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 8'h00;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign busy_o    = busy_q;
  assign rd_data_o = rd_data_q;

endmodule

@@ src/bf_instruction_stepper.sv @@
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o  bfis_pkg::in_t (load, start, step, no-op)
// out       output     out_valid_o/out_stall_i bfis_pkg::out_t (status, printed byte)
// cfg       input      cfg_valid_i/cfg_ready_o program_length, 10 bits
//
// One item is in flight at a time. Load, no-op and held-status steps go from idle
// to done; a simple instruction passes the fetch state (program and tape reads,
// then the tape write-back), and a bracket jump adds the scan read and check states
// per byte scanned through the one program port. Reset and every start clear the tape.
// A finished result waits in the output register while out_stall_i is high.
module bf_instruction_stepper #(
  parameter int unsigned PROGRAM_BYTES = bfis_pkg::DEF_PROGRAM_BYTES,
  parameter int unsigned TAPE_CELLS    = bfis_pkg::DEF_TAPE_CELLS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bfis_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bfis_pkg::out_t             out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bfis_pkg::LEN_W-1:0] cfg_data_i
);

  import bfis_pkg::*;

  localparam int unsigned PA_W  = $clog2(PROGRAM_BYTES);
  localparam int unsigned IP_W  = $clog2(PROGRAM_BYTES + 1);
  localparam int unsigned TW    = $clog2(TAPE_CELLS);
  localparam int unsigned CP_W  = $clog2(TAPE_CELLS + 1);
  localparam int unsigned CMP_W = (IP_W > LEN_W) ? IP_W : LEN_W;

  state_e          state_q, state_d;
  in_t             item_q, item_d;
  logic [IP_W-1:0] ip_q, ip_d;
  logic [CP_W-1:0] cp_q, cp_d;
  logic [2:0]      halt_q, halt_d;
  logic [IP_W-1:0] len_q, len_d;
  logic [IP_W-1:0] pos_q, pos_d;
  logic [IP_W-1:0] depth_q, depth_d;
  logic            fwd_q, fwd_d;
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            accept;
  logic            step_go;
  logic            scan_start;
  logic            scan_fail;
  logic            scan_hit;
  logic            out_free;
  logic [7:0]      cmd;
  logic [7:0]      cell_val;
  logic [7:0]      close_ch;
  logic [7:0]      open_ch;

  logic [7:0]      prog_mem [PROGRAM_BYTES];
  logic [7:0]      prog_rdata_q;
  logic            prog_we;
  logic [PA_W-1:0] prog_waddr;
  logic            prog_re;
  logic [PA_W-1:0] prog_raddr;

  logic            tape_clear;
  logic            tape_busy;
  logic            tape_re;
  logic [7:0]      tape_rdata;
  logic            tape_we;
  logic [7:0]      tape_wdata;

  // Handshakes.
  assign in_stall_o  = (state_q != S_IDLE) || tape_busy;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Decode helpers shared by the next-state and output logic.
  assign cmd        = prog_rdata_q;
  assign cell_val   = tape_rdata;
  assign step_go    = (halt_q != ST_BOUNDS) && (halt_q != ST_UNMATCHED) &&
                      (ip_q < len_q) && (cp_q < CP_W'(TAPE_CELLS));
  assign scan_start = ((cmd == CH_OPEN) && (cell_val == 8'h00)) ||
                      ((cmd == CH_CLOSE) && (cell_val != 8'h00));
  assign scan_fail  = fwd_q ? (pos_q >= len_q) : (pos_q == '0);
  assign close_ch   = fwd_q ? CH_CLOSE : CH_OPEN;
  assign open_ch    = fwd_q ? CH_OPEN : CH_CLOSE;
  assign scan_hit   = (cmd == close_ch) && (depth_q == '0);

  // Load operations write the program store straight from the input item.
  assign prog_we    = accept && (op_e'(in_data_i.operation) == OP_LOAD) &&
                      (CMP_W'(in_data_i.program_address) < CMP_W'(PROGRAM_BYTES));
  assign prog_waddr = PA_W'(CMP_W'(in_data_i.program_address));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(in_data_i.operation))
            OP_START: state_d = S_WIPE;
            OP_STEP:  state_d = step_go ? S_FETCH : S_DONE;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_FETCH:    state_d = scan_start ? S_SCAN_RD : S_DONE;
      S_SCAN_RD:  state_d = scan_fail ? S_DONE : S_SCAN_CHK;
      S_SCAN_CHK: state_d = scan_hit ? S_DONE : S_SCAN_RD;
      S_WIPE: begin
        if (!tape_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    item_d      = item_q;
    ip_d        = ip_q;
    cp_d        = cp_q;
    halt_d      = halt_q;
    pos_d       = pos_q;
    depth_d     = depth_q;
    fwd_d       = fwd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    prog_re     = 1'b0;
    prog_raddr  = ip_q[PA_W-1:0];
    tape_clear  = 1'b0;
    tape_re     = 1'b0;
    tape_we     = 1'b0;
    tape_wdata  = cell_val;

    // A transfer on the output empties the result register.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          res_d  = '{status: halt_q, output_valid: 1'b0, output_byte: 8'h00};
          case (op_e'(in_data_i.operation))
            OP_START: begin
              ip_d         = '0;
              cp_d         = '0;
              halt_d       = ST_RUNNING;
              res_d.status = ST_RUNNING;
              tape_clear   = 1'b1;
            end
            OP_STEP: begin
              if ((halt_q == ST_BOUNDS) || (halt_q == ST_UNMATCHED)) begin
                res_d.status = halt_q;
              end else if (ip_q >= len_q) begin
                res_d.status = ST_FINISHED;
              end else if (cp_q >= CP_W'(TAPE_CELLS)) begin
                halt_d       = ST_BOUNDS;
                res_d.status = ST_BOUNDS;
              end else begin
                prog_re = 1'b1;
                tape_re = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Execute the fetched command against the fetched cell.
      S_FETCH: begin
        res_d = '{status: ST_RUNNING, output_valid: 1'b0, output_byte: 8'h00};
        ip_d  = ip_q + IP_W'(1);
        case (cmd)
          CH_PLUS: begin
            tape_we    = 1'b1;
            tape_wdata = cell_val + 8'd1;
          end
          CH_MINUS: begin
            tape_we    = 1'b1;
            tape_wdata = cell_val - 8'd1;
          end
          CH_RIGHT: cp_d = cp_q + CP_W'(1);
          CH_LEFT:  cp_d = (cp_q == '0) ? CP_W'(TAPE_CELLS) : cp_q - CP_W'(1);
          CH_DOT: begin
            res_d.output_valid = 1'b1;
            res_d.output_byte  = cell_val;
          end
          CH_COMMA: begin
            if (item_q.input_present) begin
              tape_we    = 1'b1;
              tape_wdata = item_q.input_byte;
            end else begin
              res_d.status = ST_NEED_INPUT;
              ip_d         = ip_q;
            end
          end
          CH_OPEN: begin
            if (cell_val == 8'h00) begin
              ip_d    = ip_q;
              pos_d   = ip_q + IP_W'(1);
              depth_d = '0;
              fwd_d   = 1'b1;
            end
          end
          CH_CLOSE: begin
            if (cell_val != 8'h00) begin
              ip_d    = ip_q;
              pos_d   = ip_q;
              depth_d = '0;
              fwd_d   = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      // Read the next program byte of the bracket scan, or stop at either end.
      S_SCAN_RD: begin
        if (scan_fail) begin
          halt_d       = ST_UNMATCHED;
          res_d.status = ST_UNMATCHED;
        end else if (fwd_q) begin
          prog_re    = 1'b1;
          prog_raddr = pos_q[PA_W-1:0];
        end else begin
          prog_re    = 1'b1;
          pos_d      = pos_q - IP_W'(1);
          prog_raddr = pos_d[PA_W-1:0];
        end
      end

      // Track nesting depth; the matching bracket ends the scan.
      S_SCAN_CHK: begin
        if (cmd == close_ch) begin
          if (depth_q == '0) begin
            ip_d = pos_q + IP_W'(1);
          end else begin
            depth_d = depth_q - IP_W'(1);
          end
        end else if (cmd == open_ch) begin
          depth_d = depth_q + IP_W'(1);
        end
        if (fwd_q && !scan_hit) begin
          pos_d = pos_q + IP_W'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // Program length register, held clamped to the store size.
  always_comb begin
    len_d = len_q;
    if (cfg_valid_i && cfg_ready_o) begin
      len_d = (CMP_W'(cfg_data_i) > CMP_W'(PROGRAM_BYTES)) ?
              IP_W'(PROGRAM_BYTES) : IP_W'(cfg_data_i);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ip_q        <= '0;
      cp_q        <= '0;
      halt_q      <= ST_RUNNING;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ip_q        <= ip_d;
      cp_q        <= cp_d;
      halt_q      <= halt_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    pos_q   <= pos_d;
    depth_q <= depth_d;
    fwd_q   <= fwd_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // Program store: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[prog_waddr] <= in_data_i.program_byte;
    end
    if (prog_re) begin
      prog_rdata_q <= prog_mem[prog_raddr];
    end
  end

  bfis_tape #(
    .TAPE_CELLS(TAPE_CELLS)
  ) u_tape (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (tape_clear),
    .busy_o    (tape_busy),
    .rd_en_i   (tape_re),
    .rd_addr_i (cp_q[TW-1:0]),
    .rd_data_o (tape_rdata),
    .wr_en_i   (tape_we),
    .wr_addr_i (cp_q[TW-1:0]),
    .wr_data_i (tape_wdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ verif/bf_instruction_stepper_tb.sv @@
module bf_instruction_stepper_tb;
  import bfis_pkg::*;

  localparam int unsigned PROG_BYTES = DEF_PROGRAM_BYTES;
  localparam int unsigned TAPE_LEN   = DEF_TAPE_CELLS;
  localparam int          NO_CHECK   = -1;
  localparam int          SETTLE     = 8;
  localparam int          DRAIN      = 16;
  localparam int          QUIET_FROM = 920;
  localparam int          STOP_AT    = 1000;
  localparam int          TIMEOUT    = 16000000;

  // One line of the directed plan: either a length write or an item.
  typedef struct packed {
    logic           is_cfg;
    logic [LEN_W-1:0] len;
    in_t            item;
    logic           has_known;
    out_t           known;
  } drow_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_t             out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LEN_W-1:0] cfg_data_i;

  // Shadow copy of the interpreter state.
  logic [7:0]       shadow_prog [PROG_BYTES];
  logic [7:0]       shadow_tape [TAPE_LEN];
  int unsigned      shadow_ip;
  int unsigned      shadow_cp;
  logic [2:0]       shadow_halt;
  logic [LEN_W-1:0] shadow_len;

  out_t  owed_results [$];
  out_t  want_r;
  drow_t plan [$];
  int    fails;
  int    n_sent;
  bit    quiet;

  bf_instruction_stepper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog for a hung run.
  initial begin
    #(TIMEOUT);
    $display("bf_instruction_stepper_tb: FAIL");
    $finish;
  end

  task automatic note_failure(string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endtask

  // Runs one step instruction on the shadow state and returns its result.
  function automatic out_t interp_step(logic have_in, logic [7:0] in_byte);
    out_t        r;
    int unsigned len;
    int unsigned ip;
    int unsigned pos;
    int unsigned depth;
    bit          found;
    logic [7:0]  cmd;
    r = '0;
    len = (shadow_len > PROG_BYTES) ? PROG_BYTES : shadow_len;
    ip = shadow_ip;
    if (shadow_halt == ST_BOUNDS || shadow_halt == ST_UNMATCHED) begin
      r.status = shadow_halt;
      return r;
    end
    if (ip >= len) begin
      r.status = ST_FINISHED;
      return r;
    end
    if (shadow_cp >= TAPE_LEN) begin
      shadow_halt = ST_BOUNDS;
      r.status = ST_BOUNDS;
      return r;
    end
    cmd = shadow_prog[ip];
    case (cmd)
      CH_PLUS:  shadow_tape[shadow_cp] = shadow_tape[shadow_cp] + 8'd1;
      CH_MINUS: shadow_tape[shadow_cp] = shadow_tape[shadow_cp] - 8'd1;
      CH_RIGHT: shadow_cp = shadow_cp + 1;
      CH_LEFT:  shadow_cp = (shadow_cp == 0) ? TAPE_LEN : shadow_cp - 1;
      CH_DOT: begin
        r.output_valid = 1'b1;
        r.output_byte = shadow_tape[shadow_cp];
      end
      CH_COMMA: begin
        if (!have_in) begin
          r.status = ST_NEED_INPUT;
          return r;
        end
        shadow_tape[shadow_cp] = in_byte;
      end
      CH_OPEN: begin
        // Forward scan for the matching close bracket.
        if (shadow_tape[shadow_cp] == 8'd0) begin
          pos = ip + 1;
          depth = 0;
          found = 1'b0;
          while (!found) begin
            if (pos >= len) begin
              shadow_halt = ST_UNMATCHED;
              r.status = ST_UNMATCHED;
              return r;
            end
            if (shadow_prog[pos] == CH_CLOSE) begin
              if (depth == 0) found = 1'b1;
              else depth--;
            end else if (shadow_prog[pos] == CH_OPEN) begin
              depth++;
            end
            if (!found) pos++;
          end
          ip = pos;
        end
      end
      CH_CLOSE: begin
        // Backward scan for the matching open bracket.
        if (shadow_tape[shadow_cp] != 8'd0) begin
          pos = ip;
          depth = 0;
          found = 1'b0;
          while (!found) begin
            if (pos == 0) begin
              shadow_halt = ST_UNMATCHED;
              r.status = ST_UNMATCHED;
              return r;
            end
            pos--;
            if (shadow_prog[pos] == CH_OPEN) begin
              if (depth == 0) found = 1'b1;
              else depth--;
            end else if (shadow_prog[pos] == CH_CLOSE) begin
              depth++;
            end
          end
          ip = pos;
        end
      end
      default: ;
    endcase
    shadow_ip = ip + 1;
    return r;
  endfunction

  // Applies one operation to the shadow state and returns its result.
  function automatic out_t interp_op(in_t it);
    out_t r;
    r = '0;
    case (it.operation)
      OP_STEP: r = interp_step(it.input_present, it.input_byte);
      OP_LOAD: begin
        shadow_prog[it.program_address] = it.program_byte;
        r.status = shadow_halt;
      end
      OP_START: begin
        foreach (shadow_tape[i]) shadow_tape[i] = 8'd0;
        shadow_ip = 0;
        shadow_cp = 0;
        shadow_halt = ST_RUNNING;
        r.status = shadow_halt;
      end
      default: r.status = shadow_halt;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_cmd();
    logic [7:0] ch;
    case ($urandom_range(0, 7))
      0: ch = CH_PLUS;
      1: ch = CH_MINUS;
      2: ch = CH_RIGHT;
      3: ch = CH_LEFT;
      4: ch = CH_DOT;
      5: ch = CH_COMMA;
      6: ch = CH_OPEN;
      default: ch = CH_CLOSE;
    endcase
    return ch;
  endfunction

  // Item with every field but the operation random; the caller overrides what matters.
  function automatic in_t rand_item(op_e op);
    in_t it;
    it.operation = op;
    it.program_address = 9'($urandom_range(0, PROG_BYTES - 1));
    it.program_byte = 8'($urandom_range(0, 255));
    it.input_present = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 7) == 0) it.input_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else it.input_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic drow_t row(op_e op, int addr, int pb, bit have, int ib,
                                int kst, bit kv, int kb);
    drow_t d;
    d = '0;
    d.item.operation = op;
    d.item.program_address = 9'(addr);
    d.item.program_byte = 8'(pb);
    d.item.input_present = have;
    d.item.input_byte = 8'(ib);
    d.has_known = (kst != NO_CHECK);
    if (d.has_known) begin
      d.known.status = 3'(kst);
      d.known.output_valid = kv;
      d.known.output_byte = 8'(kb);
    end
    return d;
  endfunction

  function automatic drow_t cfg_row(int len);
    drow_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.len = LEN_W'(len);
    return d;
  endfunction

  // Offers one item, holds it until the transfer, and records its result.
  task automatic push_item(in_t it, bit has_known, out_t known);
    out_t pred;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = interp_op(it);
    owed_results.push_back(has_known ? known : pred);
    n_sent++;
    if (n_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic push_rand(in_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    push_item(it, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Length writes happen only with the block idle.
  task automatic set_length(logic [LEN_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_len = v;
  endtask

  // Loads a random program at the bottom of the store and runs it for a while.
  task automatic run_episode();
    logic [7:0]       text [64];
    logic [7:0]       ch;
    logic [LEN_W-1:0] cfgv;
    int               plen;
    int               nsteps;
    int               depth;
    int               r;
    bit               broken;
    in_t              it;
    plen = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 15);
    broken = ($urandom_range(0, 7) == 0);
    depth = 0;
    for (int k = 0; k < plen; k++) begin
      if (broken) begin
        ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pick_cmd();
      end else if (plen - k <= depth) begin
        ch = CH_CLOSE;
        depth--;
      end else begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3: ch = CH_PLUS;
          4, 5:       ch = CH_MINUS;
          6, 7:       ch = CH_RIGHT;
          8:          ch = CH_LEFT;
          9, 10:      ch = CH_DOT;
          11:         ch = CH_COMMA;
          12, 13: begin
            if (plen - k - 1 > depth) begin
              ch = CH_OPEN;
              depth++;
            end else begin
              ch = CH_PLUS;
            end
          end
          14: begin
            if (depth > 0) begin
              ch = CH_CLOSE;
              depth--;
            end else begin
              ch = CH_MINUS;
            end
          end
          default: begin
            ch = 8'($urandom_range(0, 255));
            if (ch == CH_OPEN || ch == CH_CLOSE) ch = 8'h23;
          end
        endcase
      end
      text[k] = ch;
    end

    // Mostly the program's own length, sometimes the extremes.
    case ($urandom_range(0, 7))
      0:       cfgv = '0;
      1:       cfgv = LEN_W'(PROG_BYTES);
      2:       cfgv = '1;
      3:       cfgv = LEN_W'($urandom_range(PROG_BYTES + 1, 1023));
      default: cfgv = LEN_W'(plen);
    endcase
    set_length(cfgv);

    for (int k = 0; k < plen; k++) begin
      it = rand_item(OP_LOAD);
      it.program_address = 9'(k);
      it.program_byte = text[k];
      push_rand(it);
    end
    push_rand(rand_item(OP_START));

    nsteps = $urandom_range(plen, 4 * plen + 8);
    for (int k = 0; k < nsteps; k++) begin
      r = $urandom_range(0, 63);
      if (r < 3) begin
        push_rand(rand_item(OP_NOP));
      end else if (r == 3) begin
        push_rand(rand_item(OP_LOAD));
      end else if (r == 4) begin
        push_rand(rand_item(OP_START));
      end else begin
        // Now and then hold off until everything owed has come back.
        if (r == 5) wait_drained();
        push_rand(rand_item(OP_STEP));
      end
    end
  endtask

  // Receiver: random stall bursts, none near the end.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Check every result transfer against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d valid %0b byte %02h",
                               out_data_o.status, out_data_o.output_valid,
                               out_data_o.output_byte));
      end else begin
        want_r = owed_results.pop_front();
        if (out_data_o.status !== want_r.status ||
            out_data_o.output_valid !== want_r.output_valid ||
            out_data_o.output_byte !== want_r.output_byte) begin
          note_failure($sformatf(
            "mismatch: expected status %0d valid %0b byte %02h, got %0d %0b %02h",
            want_r.status, want_r.output_valid, want_r.output_byte,
            out_data_o.status, out_data_o.output_valid, out_data_o.output_byte));
        end
      end
    end
  end

  // Stimulus.
  initial begin
    in_t        it;
    logic [7:0] ch;
    fails = 0;
    n_sent = 0;
    quiet = 1'b0;
    shadow_ip = 0;
    shadow_cp = 0;
    shadow_halt = ST_RUNNING;
    shadow_len = '0;
    foreach (shadow_tape[i]) shadow_tape[i] = 8'd0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a short program that prints, loops once, then walks off cell 0;
    // afterwards a forward scan that runs off the end.
    plan.push_back(row(OP_NOP,   0,   0,        0, 0, ST_RUNNING,   0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        0, 0, ST_FINISHED,  0, 0));
    plan.push_back(row(OP_LOAD,  0,   CH_COMMA, 0, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_LOAD,  1,   CH_DOT,   0, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_LOAD,  2,   CH_OPEN,  0, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_LOAD,  3,   CH_MINUS, 0, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_LOAD,  4,   CH_CLOSE, 0, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_LOAD,  5,   CH_LEFT,  0, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_LOAD,  6,   CH_PLUS,  0, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_LOAD,  511, 8'hFF,    1, 8'hFF, ST_RUNNING, 0, 0));
    plan.push_back(cfg_row(7));
    plan.push_back(row(OP_START, 0,   0,        0, 0, ST_RUNNING,   0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        0, 8'h55, ST_NEED_INPUT, 0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        1, 8'h01, NO_CHECK, 0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, ST_RUNNING,   1, 8'h01));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, ST_BOUNDS,    0, 0));
    plan.push_back(row(OP_LOAD,  0,   8'h00,    0, 0, ST_BOUNDS,    0, 0));
    plan.push_back(row(OP_LOAD,  4,   8'h5A,    0, 0, ST_BOUNDS,    0, 0));
    plan.push_back(row(OP_START, 0,   0,        0, 0, ST_RUNNING,   0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, NO_CHECK,     0, 0));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, ST_RUNNING,   1, 8'h00));
    plan.push_back(row(OP_STEP,  0,   0,        1, 0, ST_UNMATCHED, 0, 0));
    plan.push_back(row(OP_NOP,   0,   0,        1, 0, ST_UNMATCHED, 0, 0));
    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_length(plan[i].len);
      else push_item(plan[i].item, plan[i].has_known, plan[i].known);
    end

    // Fill the whole store: a long run of moves to the right first, so that
    // the pointer steps off the far end of the tape.
    for (int k = 0; k < PROG_BYTES; k++) begin
      if (k < 320 && k % 32 != 31) begin
        ch = CH_RIGHT;
      end else if (k < 320) begin
        case ($urandom_range(0, 3))
          0: ch = CH_PLUS;
          1: ch = CH_MINUS;
          2: ch = CH_DOT;
          default: ch = CH_COMMA;
        endcase
      end else begin
        ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pick_cmd();
      end
      it = rand_item(OP_LOAD);
      it.program_address = 9'(k);
      it.program_byte = ch;
      push_rand(it);
    end
    set_length('1);
    push_rand(rand_item(OP_START));
    for (int k = 0; k < 340; k++) begin
      it = rand_item(OP_STEP);
      it.input_present = ($urandom_range(0, 3) != 0);
      push_rand(it);
    end

    // Random programs until enough items have gone in.
    while (n_sent < STOP_AT) run_episode();

    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    if (fails == 0) begin
      $display("bf_instruction_stepper_tb: PASS");
    end else begin
      $display("bf_instruction_stepper_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/bfis_pkg.sv
src/bfis_tape.sv
src/bf_instruction_stepper.sv
verif/bf_instruction_stepper_tb.sv
